FILE: rtl/core/ffha_pkg.sv
// Package for the first-fit heap allocator: sizes, widths, entry record,
// controller states and the structs between the controller and the slot map.
// Depends on nothing; every other file of the block imports it.
package ffha_pkg;

    // Heap geometry and entry store size.
    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int MAX_ENTRIES  = 64;

    // Field widths.
    localparam int ADDR_W = $clog2(HEAP_BYTES);
    localparam int SIZE_W = 12;
    localparam int TAG_W  = 8;

    // Slot index, link (one more code for the null link) and walk step count.
    localparam int SLOT_W = $clog2(MAX_ENTRIES);
    localparam int LINK_W = $clog2(MAX_ENTRIES + 1);
    localparam int STEP_W = $clog2(MAX_ENTRIES + 1);

    // Gap arithmetic holds an end address plus header plus length, then plus a need.
    localparam int SPAN_W = ADDR_W + 2;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_ENTRIES);

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // One entry of the data store; the link lives in a memory of its own.
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] length;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DATA,
        ST_CHECK,
        ST_WRITE,
        ST_LINK,
        ST_DONE
    } state_t;

    // Controller to slot map.
    typedef struct packed {
        logic              scan_start;
        logic              set;
        logic              clear;
        logic [SLOT_W-1:0] idx;
    } slot_ctl_t;

    // Slot map to controller.
    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } slot_stat_t;

endpackage

FILE: rtl/core/ffha_req_if.sv
// Request channel of the heap allocator: valid/ready handshake and payload.
// Depends on ffha_pkg for the field widths.
interface ffha_req_if;
    import ffha_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [SIZE_W-1:0]        request_size;
    logic signed [TAG_W-1:0]  type_tag;
    logic [ADDR_W-1:0]        handle_address;

    modport source (
        output valid, kind, request_size, type_tag, handle_address,
        input  ready
    );

    modport sink (
        input  valid, kind, request_size, type_tag, handle_address,
        output ready
    );
endinterface

FILE: rtl/core/ffha_rsp_if.sv
// Response channel of the heap allocator: valid/ready handshake and payload.
// Depends on ffha_pkg for the field widths.
interface ffha_rsp_if;
    import ffha_pkg::*;

    logic              valid;
    logic              ready;
    logic              ok;
    logic [ADDR_W-1:0] block_address;

    modport source (
        output valid, ok, block_address,
        input  ready
    );

    modport sink (
        input  valid, ok, block_address,
        output ready
    );
endinterface

FILE: rtl/core/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator: list walk controller, entry and
// link memories, response register. Depends on ffha_pkg, ffha_req_if,
// ffha_rsp_if and ffha_slot_map.
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+-------------------------------------------------
//   req     | in  | valid/ready | kind, request_size, type_tag, handle_address
//   rsp     | out | valid/ready | ok, block_address
//
// A request walks the address-ordered list one entry at a time (memory read,
// then compare). After loading its response the controller passes through idle
// before it takes the next request. The free-slot scan, one slot a cycle, runs
// alongside the walk; an allocation waits in its check state until the scan is
// done. One request is in work at a time; a new one is taken while the previous
// response still waits in its register.
// Reset empties the list and the slot map at once; the memories need no clearing.
module first_fit_heap_allocator_unit (
    input  logic          clk,
    input  logic          rst_n,
    ffha_req_if.sink      req,
    ffha_rsp_if.source    rsp
);
    import ffha_pkg::*;

    // Memories: entry data and links, one read port each at the same address.
    entry_t            data_mem [MAX_ENTRIES];
    logic [LINK_W-1:0] link_mem [MAX_ENTRIES];
    entry_t            rd_data;
    logic [LINK_W-1:0] rd_link;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              data_we;
    logic [SLOT_W-1:0] data_wa;
    entry_t            data_wd;
    logic              link_we;
    logic [SLOT_W-1:0] link_wa;
    logic [LINK_W-1:0] link_wd;

    // Controller registers.
    state_t            state_reg, state_next;
    logic              kind_reg, kind_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SPAN_W-1:0] need_reg, need_next;
    logic [SPAN_W-1:0] start_reg, start_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [LINK_W-1:0] link_val_reg, link_val_next;
    logic              ok_reg, ok_next;
    logic [LINK_W-1:0] head_reg, head_next;

    // Response register.
    logic              rsp_valid_reg, rsp_valid_next;
    logic              rsp_ok_reg, rsp_ok_next;
    logic [ADDR_W-1:0] rsp_addr_reg, rsp_addr_next;

    slot_ctl_t  slot_ctl;
    slot_stat_t slot_stat;

    // Walk decode.
    logic              walk_end;
    logic              prev_valid;
    logic [SPAN_W-1:0] end_w;
    logic              gap_fits;
    logic [SPAN_W-1:0] after_w;
    logic              heap_over;
    logic              addr_match;
    logic              req_fire;
    logic              rsp_free;

    ffha_slot_map u_slot_map (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (slot_ctl),
        .stat  (slot_stat)
    );

    // Entry data memory.
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_wa] <= data_wd;
        end
        if (rd_en)
        begin
            rd_data <= data_mem[rd_addr];
        end
    end

    // Link memory.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (rd_en)
        begin
            rd_link <= link_mem[rd_addr];
        end
    end

    // Combinational decode of the walk.
    always_comb
    begin
        walk_end   = (steps_reg == STEP_W'(MAX_ENTRIES)) || (cur_reg >= NULL_LINK);
        prev_valid = prev_reg < NULL_LINK;
        end_w      = SPAN_W'(rd_data.start);
        gap_fits   = (end_w >= start_reg) && ((end_w - start_reg) >= need_reg);
        after_w    = end_w + SPAN_W'(HEADER_BYTES) + SPAN_W'(rd_data.length);
        heap_over  = (start_reg + need_reg) > SPAN_W'(HEAP_BYTES);
        addr_match = rd_data.start == addr_reg;
        req_fire   = req.valid && req.ready;
        rsp_free   = !rsp_valid_reg || rsp.ready;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!walk_end)
                begin
                    state_next = ST_DATA;
                end
                else if (kind_reg == KIND_ALLOC)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DATA:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    state_next = gap_fits ? ST_CHECK : ST_READ;
                end
                else
                begin
                    state_next = addr_match ? ST_LINK : ST_READ;
                end
            end
            ST_CHECK:
            begin
                if (heap_over)
                begin
                    state_next = ST_DONE;
                end
                else if (slot_stat.done)
                begin
                    state_next = slot_stat.found ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE: state_next = ST_LINK;
            ST_LINK:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the controller and next values of the datapath registers.
    always_comb
    begin
        req.ready      = state_reg == ST_IDLE;
        rd_en          = 1'b0;
        rd_addr        = cur_reg[SLOT_W-1:0];
        data_we        = 1'b0;
        data_wa        = slot_stat.slot;
        data_wd.start  = start_reg[ADDR_W-1:0];
        data_wd.length = size_reg;
        data_wd.tag    = tag_reg;
        link_we        = 1'b0;
        link_wa        = slot_stat.slot;
        link_wd        = cur_reg;
        slot_ctl.scan_start = 1'b0;
        slot_ctl.set   = 1'b0;
        slot_ctl.clear = 1'b0;
        slot_ctl.idx   = slot_stat.slot;

        kind_next      = kind_reg;
        size_next      = size_reg;
        tag_next       = tag_reg;
        addr_next      = addr_reg;
        need_next      = need_reg;
        start_next     = start_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        steps_next     = steps_reg;
        link_val_next  = link_val_reg;
        ok_next        = ok_reg;
        head_next      = head_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_ok_next    = rsp_ok_reg;
        rsp_addr_next  = rsp_addr_reg;

        case (state_reg)
            // Take a request and start the walk at the list head.
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    kind_next  = req.kind;
                    size_next  = req.request_size;
                    tag_next   = req.type_tag;
                    addr_next  = req.handle_address;
                    need_next  = SPAN_W'(HEADER_BYTES) + SPAN_W'(req.request_size);
                    start_next = '0;
                    cur_next   = head_reg;
                    prev_next  = NULL_LINK;
                    steps_next = '0;
                    ok_next    = 1'b0;
                    slot_ctl.scan_start = 1'b1;
                end
            end
            // Read the current entry unless the walk is over.
            ST_READ:
            begin
                rd_en = !walk_end;
            end
            // Test the entry, or step to the next one.
            ST_DATA:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    if (!gap_fits)
                    begin
                        start_next = after_w;
                        prev_next  = cur_reg;
                        cur_next   = rd_link;
                        steps_next = steps_reg + STEP_W'(1);
                    end
                end
                else if (addr_match)
                begin
                    link_val_next  = rd_link;
                    ok_next        = 1'b1;
                    slot_ctl.clear = 1'b1;
                    slot_ctl.idx   = cur_reg[SLOT_W-1:0];
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = rd_link;
                    steps_next = steps_reg + STEP_W'(1);
                end
            end
            // Write the new entry into the free slot; it links to the walk's stop point.
            ST_WRITE:
            begin
                data_we       = 1'b1;
                link_we       = 1'b1;
                slot_ctl.set  = 1'b1;
                link_val_next = LINK_W'(slot_stat.slot);
                ok_next       = 1'b1;
            end
            // Point the predecessor, or the head, at the new link.
            ST_LINK:
            begin
                if (prev_valid)
                begin
                    link_we = 1'b1;
                    link_wa = prev_reg[SLOT_W-1:0];
                    link_wd = link_val_reg;
                end
                else
                begin
                    head_next = link_val_reg;
                end
            end
            // Load the response register once it is free.
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = ok_reg;
                    rsp_addr_next  = (ok_reg && kind_reg == KIND_ALLOC)
                                     ? start_reg[ADDR_W-1:0] : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= NULL_LINK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        size_reg     <= size_next;
        tag_reg      <= tag_next;
        addr_reg     <= addr_next;
        need_reg     <= need_next;
        start_reg    <= start_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        steps_reg    <= steps_next;
        link_val_reg <= link_val_next;
        ok_reg       <= ok_next;
        rsp_ok_reg   <= rsp_ok_next;
        rsp_addr_reg <= rsp_addr_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.ok            = rsp_ok_reg;
    assign rsp.block_address = rsp_addr_reg;

endmodule

FILE: rtl/core/ffha_slot_map.sv
// Slot occupancy map of the heap allocator and its lowest-free-slot scanner.
// Depends on ffha_pkg for the slot widths and the control/status structs.
module ffha_slot_map (
    input  logic               clk,
    input  logic               rst_n,
    input  ffha_pkg::slot_ctl_t  ctl,
    output ffha_pkg::slot_stat_t stat
);
    import ffha_pkg::*;

    logic [MAX_ENTRIES-1:0] used_reg;
    logic [SLOT_W-1:0]      scan_idx_reg;
    logic                   done_reg;
    logic                   found_reg;

    // One bit per slot, set on allocation and cleared on free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            if (ctl.set)
            begin
                used_reg[ctl.idx] <= 1'b1;
            end
            if (ctl.clear)
            begin
                used_reg[ctl.idx] <= 1'b0;
            end
        end
    end

    // The scan checks one slot a cycle from slot 0 and stops at the first free one or after the last slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (ctl.scan_start)
        begin
            scan_idx_reg <= '0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (!done_reg)
        begin
            if (!used_reg[scan_idx_reg])
            begin
                found_reg <= 1'b1;
                done_reg  <= 1'b1;
            end
            else if (scan_idx_reg == SLOT_W'(MAX_ENTRIES - 1))
            begin
                done_reg <= 1'b1;
            end
            else
            begin
                scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
            end
        end
    end

    assign stat.done  = done_reg;
    assign stat.found = found_reg;
    assign stat.slot  = scan_idx_reg;

endmodule

FILE: bench/heap_alloc_checker.sv
// Checker for the first-fit heap allocator: watches both channels, keeps its own
// copy of the allocation list and compares each response with the oldest prediction.
// Depends on ffha_pkg, ffha_req_if and ffha_rsp_if.
module heap_alloc_checker (
    input  logic  clk,
    input  logic  rst_n,
    ffha_req_if   req,
    ffha_rsp_if   rsp,
    output int    failures,
    output int    pending
);
    import ffha_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] block_address;
    } outcome_t;

    // Shadow copy of the entry store and list bookkeeping.
    logic [ADDR_W-1:0]      slot_start  [MAX_ENTRIES];
    logic [SIZE_W-1:0]      slot_length [MAX_ENTRIES];
    logic [TAG_W-1:0]       slot_tag    [MAX_ENTRIES];
    logic [LINK_W-1:0]      slot_next   [MAX_ENTRIES];
    logic [LINK_W-1:0]      list_head;
    logic [MAX_ENTRIES-1:0] slot_busy;

    outcome_t expected_outcomes [$];

    // First-fit placement: walk the list from address 0 and take the first gap that
    // holds the header plus payload, else the space after the last entry.
    function automatic outcome_t predict_allocate(input int size, input logic [TAG_W-1:0] tag);
        int       need;
        int       start;
        int       prev;
        int       cur;
        int       slot;
        int       steps;
        outcome_t res;
        need  = HEADER_BYTES + size;
        start = 0;
        prev  = MAX_ENTRIES;
        cur   = int'(list_head);
        slot  = MAX_ENTRIES;
        res   = '0;
        for (steps = 0; steps < MAX_ENTRIES && cur < MAX_ENTRIES; steps++)
        begin
            if (int'(slot_start[cur]) >= start && int'(slot_start[cur]) - start >= need)
                break;
            start = int'(slot_start[cur]) + HEADER_BYTES + int'(slot_length[cur]);
            prev  = cur;
            cur   = int'(slot_next[cur]);
        end
        if (cur >= MAX_ENTRIES)
            cur = MAX_ENTRIES;

        // The allocation would run past the end of the heap.
        if (start + need > HEAP_BYTES)
            return res;

        // The lowest free slot is taken; with none left the request fails.
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (!slot_busy[i])
            begin
                slot = i;
                break;
            end
        end
        if (slot >= MAX_ENTRIES)
            return res;

        slot_busy[slot]   = 1'b1;
        slot_start[slot]  = start[ADDR_W-1:0];
        slot_length[slot] = size[SIZE_W-1:0];
        slot_tag[slot]    = tag;
        slot_next[slot]   = cur[LINK_W-1:0];
        if (prev < MAX_ENTRIES)
            slot_next[prev] = slot[LINK_W-1:0];
        else
            list_head = slot[LINK_W-1:0];
        res.ok            = 1'b1;
        res.block_address = start[ADDR_W-1:0];
        return res;
    endfunction

    // Unlink the entry whose header starts at the given address, if any.
    function automatic outcome_t predict_release(input logic [ADDR_W-1:0] addr);
        int       prev;
        int       cur;
        int       nxt;
        int       steps;
        outcome_t res;
        prev = MAX_ENTRIES;
        cur  = int'(list_head);
        res  = '0;
        for (steps = 0; steps < MAX_ENTRIES && cur < MAX_ENTRIES; steps++)
        begin
            nxt = int'(slot_next[cur]);
            if (slot_start[cur] == addr)
            begin
                if (prev < MAX_ENTRIES)
                    slot_next[prev] = nxt[LINK_W-1:0];
                else
                    list_head = nxt[LINK_W-1:0];
                slot_busy[cur] = 1'b0;
                res.ok = 1'b1;
                return res;
            end
            prev = cur;
            cur  = nxt;
        end
        return res;
    endfunction

    // Responses are checked before the request of the same cycle is predicted,
    // since a response can never belong to a request accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                slot_start[i]  = '0;
                slot_length[i] = '0;
                slot_tag[i]    = '0;
                slot_next[i]   = '0;
            end
            list_head = NULL_LINK;
            slot_busy = '0;
            expected_outcomes.delete();
            failures = 0;
            pending  = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("response with no request waiting: ok=%0b block_address=%0d",
                                 rsp.ok, rsp.block_address);
                end
                else
                begin
                    outcome_t want;
                    want = expected_outcomes.pop_front();
                    if (rsp.ok !== want.ok || rsp.block_address !== want.block_address)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"mismatch: expected ok=%0b block_address=%0d, ",
                                      "got ok=%0b block_address=%0d"},
                                     want.ok, want.block_address, rsp.ok, rsp.block_address);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.kind == KIND_ALLOC)
                    expected_outcomes.push_back(predict_allocate(int'(req.request_size),
                                                                 req.type_tag));
                else
                    expected_outcomes.push_back(predict_release(req.handle_address));
            end
            pending = expected_outcomes.size();
        end
    end

endmodule

FILE: bench/testbench.sv
// Top of the heap allocator bench: clock, reset, request stimulus, response stall,
// watchdog and verdict. Depends on ffha_pkg, both channel interfaces,
// first_fit_heap_allocator_unit and heap_alloc_checker.
module testbench;
    import ffha_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_ITEMS  = 190;
    localparam int FILL_ITEMS   = 80;

    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   send_idle_pct;
    int   stall_pct;

    // Kinds of requests still awaiting a response, and addresses believed live,
    // so that frees mostly target real allocations.
    logic              kinds_in_flight [$];
    logic [ADDR_W-1:0] live_blocks [$];

    ffha_req_if req_ch ();
    ffha_rsp_if rsp_ch ();

    first_fit_heap_allocator_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    heap_alloc_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .failures (failures),
        .pending  (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The response side stalls at random, at the rate of the current phase.
    initial rsp_ch.ready = 1'b0;
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

    // Track which responses belong to allocations and harvest their addresses.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready && kinds_in_flight.size() > 0)
            begin
                if (kinds_in_flight.pop_front() == KIND_ALLOC && rsp_ch.ok)
                    live_blocks.push_back(rsp_ch.block_address);
            end
            if (req_ch.valid && req_ch.ready)
                kinds_in_flight.push_back(req_ch.kind);
        end
    end

    // Watchdog: too long without any handshake ends the run.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Present one request at a falling edge, after a random idle gap, and hold it
    // until it is accepted.
    task automatic issue_request(input logic kind, input logic [SIZE_W-1:0] size,
                                 input logic signed [TAG_W-1:0] tag,
                                 input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid          <= 1'b1;
        req_ch.kind           <= kind;
        req_ch.request_size   <= size;
        req_ch.type_tag       <= tag;
        req_ch.handle_address <= addr;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    initial
    begin : stimulus
        int                       r;
        int                       idx;
        logic                     kind;
        logic [SIZE_W-1:0]        size;
        logic [ADDR_W-1:0]        addr;
        logic signed [TAG_W-1:0]  tag;

        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.kind           = KIND_ALLOC;
        req_ch.request_size   = '0;
        req_ch.type_tag       = '0;
        req_ch.handle_address = '0;
        send_idle_pct         = 0;
        stall_pct             = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty-list free, a heap-sized block, heap end, reuse of
        // an exact gap, a gap too small, frees that miss, and an exact fit at the end.
        issue_request(KIND_FREE,  12'd4088, -8'sd1,   12'd0);
        issue_request(KIND_ALLOC, 12'd4088, -8'sd128, 12'd4095);
        issue_request(KIND_ALLOC, 12'd0,    8'sd127,  12'd0);
        issue_request(KIND_FREE,  12'd0,    8'sd0,    12'd0);
        issue_request(KIND_FREE,  12'd0,    8'sd0,    12'd0);
        issue_request(KIND_ALLOC, 12'd0,    8'sd0,    12'd0);
        issue_request(KIND_ALLOC, 12'd0,    8'sd5,    12'd0);
        issue_request(KIND_ALLOC, 12'd16,   -8'sd7,   12'd0);
        issue_request(KIND_FREE,  12'd0,    8'sd0,    12'd8);
        issue_request(KIND_ALLOC, 12'd0,    8'sd1,    12'd0);
        issue_request(KIND_ALLOC, 12'd1,    8'sd2,    12'd0);
        issue_request(KIND_FREE,  12'd0,    8'sd0,    12'd16);
        issue_request(KIND_ALLOC, 12'd20,   8'sd3,    12'd0);
        issue_request(KIND_ALLOC, 12'd16,   8'sd4,    12'd0);
        issue_request(KIND_FREE,  12'd0,    8'sd0,    12'd20);
        issue_request(KIND_FREE,  12'd4095, -8'sd1,   12'd4095);
        issue_request(KIND_ALLOC, 12'd4088, 8'sd9,    12'd0);
        issue_request(KIND_ALLOC, 12'd4011, 8'sd10,   12'd0);
        issue_request(KIND_ALLOC, 12'd0,    8'sd11,   12'd0);
        issue_request(KIND_FREE,  12'd0,    8'sd0,    12'd77);

        // Random part, one phase per idling pattern. Each phase starts with FILL_ITEMS
        // requests, mostly small allocations to fill the store, then mixes traffic.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 50; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 50; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                size = SIZE_W'($urandom_range(4095));
                tag  = TAG_W'($urandom_range(255));
                addr = ADDR_W'($urandom_range(4095));
                if (n < FILL_ITEMS)
                    kind = ($urandom_range(99) < 88) ? KIND_ALLOC : KIND_FREE;
                else
                    kind = ($urandom_range(99) < 50) ? KIND_ALLOC : KIND_FREE;

                if (kind == KIND_ALLOC)
                begin
                    r = $urandom_range(99);
                    if (n < FILL_ITEMS || r < 50)
                        size = SIZE_W'($urandom_range(n < FILL_ITEMS ? 15 : 63));
                    else if (r < 85)
                        size = SIZE_W'($urandom_range(511, 64));
                    else if (r < 98)
                        size = SIZE_W'($urandom_range(4088, 512));
                    else
                        size = 12'd4088;
                end
                else
                begin
                    // Mostly live blocks, some header-aligned guesses, some noise.
                    r = $urandom_range(99);
                    if (r < 75 && live_blocks.size() > 0)
                    begin
                        idx  = $urandom_range(live_blocks.size() - 1);
                        addr = live_blocks[idx];
                        live_blocks.delete(idx);
                    end
                    else if (r < 90)
                        addr = {9'($urandom_range(511)), 3'b000};
                end
                issue_request(kind, size, tag, addr);
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Let every outstanding response come back, then a tail for strays.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
